// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the goal controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/tdtgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdtgc_pkg
// Types, constants and the arctangent table of the goal controller.
// ----------------------------------------------------------------------------
package tdtgc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POS_W  = 32;
  localparam int DIFF_W = 33;
  localparam int VEC_W  = 36;
  localparam int ANG_W  = 36;
  localparam int DIST_W = 31;
  localparam int SQ_W   = 2 * DIST_W;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  localparam logic [14:0] RST_LIN  = 15'd2048;
  localparam logic [14:0] RST_ANG  = 15'd8192;
  localparam logic [14:0] RST_HTOL = 15'd410;
  localparam logic [30:0] RST_DTOL = 31'd6554;

  typedef enum logic [1:0] {
    REG_LIN  = 2'd0,
    REG_ANG  = 2'd1,
    REG_HTOL = 2'd2,
    REG_DTOL = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TURN  = 2'd1,
    PH_DRIVE = 2'd2,
    PH_ALIGN = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CALC  = 2'd1,
    S_FINAL = 2'd2,
    S_OUT   = 2'd3
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd31: r = '0;
      default: r = ANG_W'(36'sd1 <<< (5'd30 - i));
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/tdtgc_cordic.sv =====
// ----------------------------------------------------------------------------
// tdtgc_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tdtgc_cordic #(
  parameter int CORDIC_STEPS = tdtgc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic signed [tdtgc_pkg::DIFF_W-1:0]        x_in,
  input  logic signed [tdtgc_pkg::DIFF_W-1:0]        y_in,
  output logic                                       busy,
  output logic                                       zero_vec,
  output logic signed [tdtgc_pkg::ANG_W-1:0]         z
);
  import tdtgc_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic signed [VEC_W-1:0] x, y, xs, ys, xi, yi;
  logic [CW-1:0] cnt;

  assign xi = VEC_W'(x_in);
  assign yi = VEC_W'(y_in);
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_vec <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x <= -xi;
        y <= -yi;
        z <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x <= xi;
        y <= yi;
        z <= '0;
      end
    end else if (busy) begin
      // rotate toward the x axis, accumulate the angle
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_q30(5'(cnt));
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_q30(5'(cnt));
      end
    end
  end

endmodule

// ===== hdl/tdtgc_sqr.sv =====
// ----------------------------------------------------------------------------
// tdtgc_sqr
// Bit-serial squarer: one multiplier bit per cycle, shift-and-add.
// ----------------------------------------------------------------------------
module tdtgc_sqr (
  input  logic                              clk,
  input  logic                              rst,
  input  tdtgc_pkg::unit_ctl_t              ctl_in,
  input  logic [tdtgc_pkg::DIST_W-1:0]      a,
  output logic                              busy,
  output logic [tdtgc_pkg::SQ_W-1:0]        sq
);
  import tdtgc_pkg::*;

  localparam int CW = $clog2(DIST_W);

  logic [DIST_W-1:0] m;
  logic [DIST_W:0]   sum;
  logic [CW-1:0]     cnt;

  assign sum = {1'b0, sq[SQ_W-1:DIST_W]} + (sq[0] ? {1'b0, m} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl_in.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIST_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      m  <= a;
      sq <= {{DIST_W{1'b0}}, a};
    end else if (busy) begin
      sq <= {sum, sq[DIST_W-1:1]};
    end
  end

endmodule

// ===== hdl/turn_drive_turn_goal_controller_core.sv =====
// ----------------------------------------------------------------------------
// turn_drive_turn_goal_controller_core
// Turn, drive, turn controller: goal beats store a pose, odometry beats
// return one velocity command beat each.
// ----------------------------------------------------------------------------
// Goal beat: taken while idle, no result beat.
// Odometry beat: result registered in S_FINAL and valid in S_OUT once the CORDIC and
//   all squarers finish (the distance squarers start in the cycle after it is taken).
// One beat in flight: the next odometry beat is taken only after the result beat is
//   accepted, which out_ready can hold off; in_ready is high only while idle.
// Reset: phase idle, goal zero, registers at their documented defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module turn_drive_turn_goal_controller_core #(
  parameter int CORDIC_STEPS = tdtgc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               vel_valid,
  output logic [14:0]        linear_speed,
  output logic signed [15:0] angular_speed,
  output logic               arrived,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tdtgc_pkg::*;

  // configuration registers
  logic [14:0] max_lin, max_ang, head_tol;
  logic [30:0] dist_tol;
  reg_idx_t    widx;

  // controller state
  state_t state, state_next;
  phase_t phase;
  logic signed [31:0] goal_x, goal_y;
  logic signed [15:0] goal_heading, yaw_s;
  logic signed [DIFF_W-1:0] dx, dy, dx_next, dy_next;
  logic [DIFF_W-1:0] ax, ay;
  logic start;

  // unit hookup
  unit_ctl_t sqr_ctl;
  logic cor_busy, cor_zero, sx_busy, sy_busy, st_busy;
  logic signed [ANG_W-1:0] cor_z;
  logic [SQ_W-1:0] sq_x, sq_y, sq_t;

  // result evaluation
  logic signed [ANG_W-1:0] zr;
  logic signed [17:0] bear, ref_ang, err, err_w, abs_e, lim, rate;
  logic [SQ_W:0] sum_sq;
  logic near, head_ok;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lin  <= RST_LIN;
      max_ang  <= RST_ANG;
      head_tol <= RST_HTOL;
      dist_tol <= RST_DTOL;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_LIN:  max_lin  <= pwdata[14:0];
        REG_ANG:  max_ang  <= pwdata[14:0];
        REG_HTOL: head_tol <= pwdata[14:0];
        REG_DTOL: dist_tol <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_LIN:  prdata = {17'b0, max_lin};
      REG_ANG:  prdata = {17'b0, max_ang};
      REG_HTOL: prdata = {17'b0, head_tol};
      REG_DTOL: prdata = {1'b0, dist_tol};
    endcase
  end

  // form goal minus position at full width, no wrap
  assign dx_next = DIFF_W'(goal_x) - DIFF_W'(pos_x);
  assign dy_next = DIFF_W'(goal_y) - DIFF_W'(pos_y);
  assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && func) state_next = S_CALC;
      S_CALC:  if (!cor_busy && !sx_busy && !sy_busy && !st_busy) state_next = S_FINAL;
      S_FINAL: state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
    endcase
  end

  // handshake and unit start
  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    start     = (state == S_IDLE) && in_valid && func;
    sqr_ctl   = '{start: start, busy: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the odometry beat
  always_ff @(posedge clk) begin
    if (start) begin
      dx    <= dx_next;
      dy    <= dy_next;
      yaw_s <= yaw;
    end
  end

  tdtgc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .start,
    .x_in(dx_next), .y_in(dy_next),
    .busy(cor_busy), .zero_vec(cor_zero), .z(cor_z)
  );

  // the x and y squarers run on the latched differences in the cycle after start
  logic start_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_d <= 1'b0;
    end else begin
      start_d <= start;
    end
  end

  unit_ctl_t sq_ctl_d;
  assign sq_ctl_d = '{start: start_d, busy: 1'b0};

  tdtgc_sqr u_sqr_x (.clk, .rst, .ctl_in(sq_ctl_d), .a(ax[DIST_W-1:0]),
                     .busy(sx_busy), .sq(sq_x));
  tdtgc_sqr u_sqr_y (.clk, .rst, .ctl_in(sq_ctl_d), .a(ay[DIST_W-1:0]),
                     .busy(sy_busy), .sq(sq_y));
  tdtgc_sqr u_sqr_t (.clk, .rst, .ctl_in(sqr_ctl), .a(dist_tol),
                     .busy(st_busy), .sq(sq_t));

  // round Q6.30 to Q3.13, clamp to plus or minus pi; zero vector gives zero
  always_comb begin
    zr = (cor_z + ANG_W'(65536)) >>> 17;
    if (cor_zero) begin
      bear = '0;
    end else if (zr > ANG_W'(PI_Q13)) begin
      bear = PI_Q13;
    end else if (zr < -ANG_W'(PI_Q13)) begin
      bear = -PI_Q13;
    end else begin
      bear = 18'(zr);
    end
    ref_ang = (phase == PH_ALIGN) ? 18'(goal_heading) : bear;
    err     = ref_ang - 18'(yaw_s);
    if (err > PI_Q13) begin
      err_w = err - TWO_PI_Q13;
    end else if (err < -PI_Q13) begin
      err_w = err + TWO_PI_Q13;
    end else begin
      err_w = err;
    end
    abs_e   = (err_w < 0) ? -err_w : err_w;
    head_ok = abs_e < {3'b0, head_tol};
    lim     = {3'b0, max_ang};
    if (err_w > lim) begin
      rate = lim;
    end else if (err_w < -lim) begin
      rate = -lim;
    end else begin
      rate = err_w;
    end
    sum_sq = {1'b0, sq_x} + {1'b0, sq_y};
    near   = (ax < DIFF_W'(dist_tol)) && (ay < DIFF_W'(dist_tol)) &&
             (sum_sq < {1'b0, sq_t});
  end

  // goal capture, phase advance, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      goal_x       <= '0;
      goal_y       <= '0;
      goal_heading <= '0;
    end else if (state == S_IDLE && in_valid && !func) begin
      goal_x       <= pos_x;
      goal_y       <= pos_y;
      goal_heading <= yaw;
      phase        <= PH_TURN;
    end else if (state == S_FINAL) begin
      vel_valid     <= 1'b0;
      linear_speed  <= '0;
      angular_speed <= '0;
      arrived       <= 1'b0;
      unique case (phase)
        PH_IDLE: ;
        PH_TURN: begin
          vel_valid     <= 1'b1;
          angular_speed <= head_ok ? '0 : 16'(rate);
          if (head_ok) phase <= PH_DRIVE;
        end
        PH_DRIVE: begin
          vel_valid     <= 1'b1;
          linear_speed  <= near ? '0 : max_lin;
          angular_speed <= near ? '0 : 16'(rate);
          if (near) phase <= PH_ALIGN;
        end
        PH_ALIGN: begin
          vel_valid     <= 1'b1;
          angular_speed <= head_ok ? '0 : 16'(rate);
          arrived       <= head_ok;
          if (head_ok) phase <= PH_IDLE;
        end
      endcase
    end
  end

  // never take a beat while a result beat waits
  `ASSERT_CLK(a_one_in_flight, !(in_ready && out_valid), "input taken with result pending")
  // done only comes with a command
  `ASSERT_IMPL(a_done_valid, out_valid && arrived, vel_valid, "done without command")
  // an idle result is all zero
  `ASSERT_IMPL(a_idle_zero, out_valid && !vel_valid,
               linear_speed == '0 && angular_speed == '0, "idle result not zero")

endmodule
